### rtl/brro_pkg.sv
// Shared types and constants for the broadcast event ring with reader offsets.
package brro_pkg;

    localparam int SEQ_W       = 48;
    localparam int WORD_W      = 64;
    localparam int KIND_W      = 3;
    localparam int RID_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 120;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [KIND_W-1:0] KIND_EMIT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNSUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POLL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEQ    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [2:0] {
        OP_EMIT,
        OP_SUB,
        OP_UNSUB,
        OP_POLL,
        OP_SEQ,
        OP_NOP
    } brro_op_t;

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_EXEC,
        ST_RING
    } brro_state_t;

    typedef struct packed {
        brro_op_t            op;
        logic [WORD_W-1:0]   event_word;
        logic [RID_W-1:0]    reader_id;
    } brro_item_t;

endpackage

### rtl/brro_front.sv
// Input side: accepts transactions and decodes the operation kind.
module brro_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brro_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            push_valid,
    input  logic                            push_ready,
    output brro_pkg::brro_item_t            push_item
);

    logic [brro_pkg::KIND_W-1:0] kind;

    assign kind       = s_tdata[2:0];
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_item.event_word = s_tdata[66:3];
        push_item.reader_id  = s_tdata[69:67];
        case (kind)
            brro_pkg::KIND_EMIT:  push_item.op = brro_pkg::OP_EMIT;
            brro_pkg::KIND_SUB:   push_item.op = brro_pkg::OP_SUB;
            brro_pkg::KIND_UNSUB: push_item.op = brro_pkg::OP_UNSUB;
            brro_pkg::KIND_POLL:  push_item.op = brro_pkg::OP_POLL;
            brro_pkg::KIND_SEQ:   push_item.op = brro_pkg::OP_SEQ;
            default:              push_item.op = brro_pkg::OP_NOP;
        endcase
    end

endmodule

### rtl/brro_queue.sv
// Short queue of decoded operations between the input side and the executor.
module brro_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  brro_pkg::brro_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output brro_pkg::brro_item_t  out_item
);

    brro_pkg::brro_item_t                store_reg [brro_pkg::QUEUE_DEPTH];
    logic [brro_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [brro_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [brro_pkg::QUEUE_CW-1:0]       count_reg, count_next;
    logic                                push, pop;

    assign in_ready  = (count_reg != brro_pkg::QUEUE_CW'(brro_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/brro_back.sv
// Executor: event ring, reader table, sequence state and result register.
module brro_back #(
    parameter int RING_DEPTH  = 16,
    parameter int MAX_READERS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  brro_pkg::brro_item_t            q_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [brro_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RID_AW   = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int FILL_W   = $clog2(RING_DEPTH + 1);
    localparam int ID_SLOTS = (MAX_READERS < 8) ? MAX_READERS : 8;
    localparam int SEQ_W    = brro_pkg::SEQ_W;
    localparam int WORD_W   = brro_pkg::WORD_W;

    brro_pkg::brro_state_t      state_reg, state_next;
    brro_pkg::brro_item_t       item_reg;
    logic [SEQ_W-1:0]           next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]           oldest_reg, oldest_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [RING_AW-1:0]         wr_slot_reg, wr_slot_next;
    logic [MAX_READERS-1:0]     rvalid_reg, rvalid_next;

    logic [WORD_W-1:0]          ring_mem [RING_DEPTH];
    logic [WORD_W-1:0]          ring_rdata_reg;
    logic [SEQ_W-1:0]           offset_mem [MAX_READERS];
    logic [SEQ_W-1:0]           offset_rdata_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [brro_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]          event_reg, event_next;
    logic [brro_pkg::RID_W-1:0] granted_reg, granted_next;
    logic [SEQ_W-1:0]           total_reg, total_next;

    logic                       out_free, load_out;
    logic                       pop, off_rd_en, off_wr_en, ring_wr_en, ring_rd_en;
    logic [RID_AW-1:0]          off_waddr;
    logic [SEQ_W-1:0]           off_wdata;
    logic [RING_AW-1:0]         ring_raddr;

    logic [RID_AW-1:0]          rid_idx;
    logic                       rid_known;
    logic                       sub_found;
    logic [brro_pkg::RID_W-1:0] sub_grant;
    logic                       caught_up, clamp, poll_deliver;
    logic [SEQ_W-1:0]           lag, off_inc, new_off;
    logic [FILL_W-1:0]          span, wr_ext, slot_wide;

    assign out_free = !m_valid_reg || m_tready;
    assign q_ready  = pop;

    // Decode reader and poll arithmetic
    assign rid_idx   = RID_AW'(item_reg.reader_id);
    assign rid_known = (32'(item_reg.reader_id) < MAX_READERS) && rvalid_reg[rid_idx];
    assign caught_up = (offset_rdata_reg >= next_seq_reg);
    assign lag       = next_seq_reg - offset_rdata_reg;
    assign clamp     = (lag > SEQ_W'(fill_reg));
    assign span      = clamp ? fill_reg : FILL_W'(lag);
    assign off_inc   = clamp ? oldest_reg + 1'b1 : offset_rdata_reg + 1'b1;
    assign new_off   = (span == '0) ? oldest_reg : off_inc;
    assign wr_ext    = FILL_W'(wr_slot_reg);
    assign slot_wide = (wr_ext >= span) ? wr_ext - span
                                        : wr_ext + FILL_W'(RING_DEPTH) - span;
    assign ring_raddr = RING_AW'(slot_wide);
    assign poll_deliver = (item_reg.op == brro_pkg::OP_POLL) && rid_known
                          && !caught_up && (span != '0);

    always_comb begin
        sub_found = 1'b0;
        sub_grant = '0;
        for (int i = 0; i < ID_SLOTS; i++) begin
            if (!sub_found && !rvalid_reg[i]) begin
                sub_found = 1'b1;
                sub_grant = brro_pkg::RID_W'(i);
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brro_pkg::ST_FETCH: begin
                if (q_valid) begin
                    state_next = brro_pkg::ST_EXEC;
                end
            end
            brro_pkg::ST_EXEC: begin
                if (out_free) begin
                    state_next = poll_deliver ? brro_pkg::ST_RING : brro_pkg::ST_FETCH;
                end
            end
            brro_pkg::ST_RING: begin
                if (out_free) begin
                    state_next = brro_pkg::ST_FETCH;
                end
            end
            default: state_next = brro_pkg::ST_FETCH;
        endcase
    end

    // Outputs and state updates
    always_comb begin
        pop           = 1'b0;
        off_rd_en     = 1'b0;
        off_wr_en     = 1'b0;
        off_waddr     = rid_idx;
        off_wdata     = new_off;
        ring_wr_en    = 1'b0;
        ring_rd_en    = 1'b0;
        load_out      = 1'b0;
        next_seq_next = next_seq_reg;
        oldest_next   = oldest_reg;
        fill_next     = fill_reg;
        wr_slot_next  = wr_slot_reg;
        rvalid_next   = rvalid_reg;
        status_next   = brro_pkg::STATUS_OK;
        event_next    = '0;
        granted_next  = '0;
        total_next    = next_seq_reg;
        case (state_reg)
            brro_pkg::ST_FETCH: begin
                pop       = q_valid;
                off_rd_en = q_valid;
            end
            brro_pkg::ST_EXEC: begin
                if (out_free) begin
                    load_out = !poll_deliver;
                    case (item_reg.op)
                        brro_pkg::OP_EMIT: begin
                            ring_wr_en    = 1'b1;
                            next_seq_next = next_seq_reg + 1'b1;
                            total_next    = next_seq_reg + 1'b1;
                            if (fill_reg < FILL_W'(RING_DEPTH)) begin
                                fill_next = fill_reg + 1'b1;
                            end else begin
                                oldest_next = oldest_reg + 1'b1;
                            end
                            wr_slot_next = (wr_slot_reg == RING_AW'(RING_DEPTH - 1))
                                           ? '0 : wr_slot_reg + 1'b1;
                        end
                        brro_pkg::OP_SUB: begin
                            if (sub_found) begin
                                rvalid_next[RID_AW'(sub_grant)] = 1'b1;
                                off_wr_en    = 1'b1;
                                off_waddr    = RID_AW'(sub_grant);
                                off_wdata    = next_seq_reg;
                                granted_next = sub_grant;
                            end else begin
                                status_next = brro_pkg::STATUS_FULL;
                            end
                        end
                        brro_pkg::OP_UNSUB: begin
                            if (rid_known) begin
                                rvalid_next[rid_idx] = 1'b0;
                            end else begin
                                status_next = brro_pkg::STATUS_UNKNOWN;
                            end
                        end
                        brro_pkg::OP_POLL: begin
                            if (!rid_known) begin
                                status_next = brro_pkg::STATUS_UNKNOWN;
                            end else if (caught_up) begin
                                status_next = brro_pkg::STATUS_EMPTY;
                            end else begin
                                off_wr_en = 1'b1;
                                if (span == '0) begin
                                    status_next = brro_pkg::STATUS_EMPTY;
                                end else begin
                                    ring_rd_en = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            brro_pkg::ST_RING: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    event_next = ring_rdata_reg;
                end
            end
            default: begin
            end
        endcase
        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= brro_pkg::ST_FETCH;
            next_seq_reg <= '0;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            wr_slot_reg  <= '0;
            rvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_seq_reg <= next_seq_next;
            oldest_reg   <= oldest_next;
            fill_reg     <= fill_next;
            wr_slot_reg  <= wr_slot_next;
            rvalid_reg   <= rvalid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= q_item;
        end
        if (load_out) begin
            status_reg  <= status_next;
            event_reg   <= event_next;
            granted_reg <= granted_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_wr_en) begin
            ring_mem[wr_slot_reg] <= item_reg.event_word;
        end
        if (ring_rd_en) begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (off_wr_en) begin
            offset_mem[off_waddr] <= off_wdata;
        end
        if (off_rd_en) begin
            offset_rdata_reg <= offset_mem[RID_AW'(q_item.reader_id)];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, total_reg, granted_reg, event_reg, status_reg};

endmodule

### rtl/broadcast_ring_with_reader_offsets.sv
// Top level of the broadcast event ring with per-reader offsets.
//
// Usage: every s_ transaction carries one operation (emit, subscribe,
// unsubscribe, poll, read sequence count) and yields exactly one m_
// transaction with status, polled event, granted reader slot and the
// running count of emitted events, in order.
// Operations are decoded into a two-entry queue; the executor takes one
// at a time. In the executor each passes through a reader offset memory
// read, then execute; a poll that delivers an event then adds a registered
// read of the ring memory.
// Reset clears the sequence count, fill level and all reader slots; ring
// and offset contents stay as they are until written. No clearing pass.
// When m_tready is low the result stays in the output register; the
// executor holds the next operation and the queue fills, then s_tready
// drops until the receiver takes the result.
module broadcast_ring_with_reader_offsets #(
    parameter int RING_DEPTH  = 16,
    parameter int MAX_READERS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // kind[2:0], event_word[66:3], reader_id[69:67], zero pad
    input  logic [brro_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], event_out[65:2], assigned_id[68:66], total_emitted[116:69], pad
    output logic [brro_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                  push_valid, push_ready;
    brro_pkg::brro_item_t  push_item;
    logic                  q_valid, q_ready;
    brro_pkg::brro_item_t  q_item;

    brro_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    brro_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    brro_back #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
